// ===== rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg
// Types and constants shared by the bounding sphere merge pipeline.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned RootW = 33;
  localparam int unsigned RadW  = 2 * RootW;
  localparam int unsigned RemW  = RootW + 3;
  localparam int unsigned QuoW  = 33;
  localparam int unsigned NumW  = 66;

  localparam logic [30:0] RadiusMax = 31'h7FFF_FFFF;
  localparam logic [62:0] GrowthMax = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] a_centre_x;
    logic signed [31:0] a_centre_y;
    logic signed [31:0] a_centre_z;
    logic [30:0]        a_radius;
    logic signed [31:0] b_centre_x;
    logic signed [31:0] b_centre_y;
    logic signed [31:0] b_centre_z;
    logic [30:0]        b_radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0] merged_centre_x;
    logic signed [31:0] merged_centre_y;
    logic signed [31:0] merged_centre_z;
    logic [30:0]        merged_radius;
    logic [62:0]        growth;
    logic               contained;
  } out_t;

  typedef struct packed {
    logic [2:0][31:0] ac;
    logic [2:0][31:0] bc;
    logic [2:0]       dneg;
    logic [2:0][32:0] ad;
    logic [30:0]      ra;
    logic [30:0]      rb;
    logic             contained;
    logic [32:0]      span;
    logic [32:0]      r;
    logic [62:0]      growth;
  } ctx_t;

endpackage

// ===== rtl/bounding_sphere_merge_top.sv =====
// ----------------------------------------------------------------------------
// bounding_sphere_merge_top
// Smallest sphere enclosing two spheres, fully pipelined.
// ----------------------------------------------------------------------------
// One item is taken every cycle; busy is never raised. Each result appears on
// res_o with res_vld_o high for one cycle, in order. The pipeline is made of
// the square root chain (33 cells, one root bit each) and the divide chain
// (33 cells, one quotient bit each), plus five stages of offset, products and
// growth, and the output register.
// The receiver cannot stall the block, so results must be taken as they come.
module bounding_sphere_merge_top import bsm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  req_i,
  output out_t res_o,
  output logic res_vld_o
);

  logic [RootW:0]              sv;
  ctx_t [RootW:0]              sctx;
  logic [RootW:0][RadW-1:0]    srad;
  logic [RootW:0][RemW-1:0]    srem;
  logic [RootW:0][RootW-1:0]   sroot;

  logic                        mv;
  ctx_t                        mctx;
  logic [2:0][NumW-1:0]        mnum;

  logic [QuoW:0]               dv;
  ctx_t [QuoW:0]               dctx;
  logic [QuoW:0][2:0][QuoW-1:0] drem, dnum, dquo;

  out_t res_d, res_q;
  logic vld_q;

  assign busy = 1'b0;

  bsm_pre u_pre (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (start),
    .req_i (req_i),
    .vld_o (sv[0]),
    .ctx_o (sctx[0]),
    .rad_o (srad[0])
  );

  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    bsm_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (sv[k]),
      .ctx_i (sctx[k]),
      .rad_i (srad[k]),
      .rem_i (srem[k]),
      .root_i(sroot[k]),
      .vld_o (sv[k+1]),
      .ctx_o (sctx[k+1]),
      .rad_o (srad[k+1]),
      .rem_o (srem[k+1]),
      .root_o(sroot[k+1])
    );
  end

  bsm_mid u_mid (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (sv[RootW]),
    .ctx_i (sctx[RootW]),
    .dist_i(sroot[RootW]),
    .vld_o (mv),
    .ctx_o (mctx),
    .num_o (mnum)
  );

  assign dv[0]   = mv;
  assign dctx[0] = mctx;
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign drem[0][i] = mnum[i][NumW-1 -: QuoW];
    assign dnum[0][i] = mnum[i][QuoW-1:0];
    assign dquo[0][i] = '0;
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    bsm_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (dv[k]),
      .ctx_i (dctx[k]),
      .rem_i (drem[k]),
      .num_i (dnum[k]),
      .quo_i (dquo[k]),
      .vld_o (dv[k+1]),
      .ctx_o (dctx[k+1]),
      .rem_o (drem[k+1]),
      .num_o (dnum[k+1]),
      .quo_o (dquo[k+1])
    );
  end

  always_comb begin
    logic [2:0][31:0] cen;
    ctx_t             c;
    logic             take_a;
    c      = dctx[QuoW];
    take_a = c.ra > c.rb;
    for (int i = 0; i < 3; i++) begin
      logic [32:0] base, cc;
      base = {c.ac[i][31], c.ac[i]};
      cc   = c.dneg[i] ? (base - dquo[QuoW][i]) : (base + dquo[QuoW][i]);
      if (c.contained) begin
        cen[i] = take_a ? c.ac[i] : c.bc[i];
      end else begin
        cen[i] = cc[31:0];
      end
    end
    res_d.merged_centre_x = cen[0];
    res_d.merged_centre_y = cen[1];
    res_d.merged_centre_z = cen[2];
    if (c.contained) begin
      res_d.merged_radius = take_a ? c.ra : c.rb;
    end else if (c.r[32:31] != 2'b00) begin
      res_d.merged_radius = RadiusMax;
    end else begin
      res_d.merged_radius = c.r[30:0];
    end
    res_d.growth    = c.growth;
    res_d.contained = c.contained;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dv[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o     = res_q;
  assign res_vld_o = vld_q;

endmodule

// ===== rtl/bsm_pre.sv =====
// ----------------------------------------------------------------------------
// bsm_pre
// Centre offset, squared distance and containment test (two stages).
// ----------------------------------------------------------------------------
module bsm_pre import bsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  in_t              req_i,
  output logic             vld_o,
  output ctx_t             ctx_o,
  output logic [RadW-1:0]  rad_o
);

  logic [2:0][31:0] ac, bc;
  logic [2:0][32:0] ad;
  logic [2:0]       dneg;
  logic [2:0][65:0] sq;
  logic [30:0]      rd;
  logic [61:0]      rd2;
  ctx_t             ctx1_d, ctx2_d;

  logic             v1_q, v2_q;
  ctx_t             ctx1_q, ctx2_q;
  logic [2:0][65:0] sq_q;
  logic [61:0]      rd2_q;
  logic [65:0]      d2, rad_q;

  always_comb begin
    ac = {req_i.a_centre_z, req_i.a_centre_y, req_i.a_centre_x};
    bc = {req_i.b_centre_z, req_i.b_centre_y, req_i.b_centre_x};
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] dx;
      dx      = $signed({bc[i][31], bc[i]}) - $signed({ac[i][31], ac[i]});
      dneg[i] = dx[32];
      ad[i]   = dx[32] ? (~dx + 33'd1) : dx;
      sq[i]   = 66'(ad[i]) * 66'(ad[i]);
    end
    rd     = (req_i.b_radius >= req_i.a_radius) ? (req_i.b_radius - req_i.a_radius)
                                                 : (req_i.a_radius - req_i.b_radius);
    rd2    = 62'(rd) * 62'(rd);
    ctx1_d = '0;
    ctx1_d.ac   = ac;
    ctx1_d.bc   = bc;
    ctx1_d.dneg = dneg;
    ctx1_d.ad   = ad;
    ctx1_d.ra   = req_i.a_radius;
    ctx1_d.rb   = req_i.b_radius;
  end

  assign d2 = sq_q[0] + sq_q[1] + sq_q[2];

  always_comb begin
    ctx2_d           = ctx1_q;
    ctx2_d.contained = (d2 <= {4'b0, rd2_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q <= ctx1_d;
    sq_q   <= sq;
    rd2_q  <= rd2;
    ctx2_q <= ctx2_d;
    rad_q  <= d2;
  end

  assign vld_o = v2_q;
  assign ctx_o = ctx2_q;
  assign rad_o = rad_q;

endmodule

// ===== rtl/bsm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// bsm_sqrt_cell
// One root bit of the digit-by-digit square root.
// ----------------------------------------------------------------------------
module bsm_sqrt_cell import bsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  ctx_t             ctx_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [RootW-1:0] root_i,
  output logic             vld_o,
  output ctx_t             ctx_o,
  output logic [RadW-1:0]  rad_o,
  output logic [RemW-1:0]  rem_o,
  output logic [RootW-1:0] root_o
);

  logic [RemW-1:0]  rem_n, trial, rem_d;
  logic [RootW-1:0] root_d;
  logic             vld_q;
  ctx_t             ctx_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;

  always_comb begin
    rem_n = {rem_i[RemW-3:0], rad_i[RadW-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    if (rem_n >= trial) begin
      rem_d  = rem_n - trial;
      root_d = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_d  = rem_n;
      root_d = {root_i[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q  <= ctx_i;
    rad_q  <= {rad_i[RadW-3:0], 2'b00};
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign vld_o  = vld_q;
  assign ctx_o  = ctx_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== rtl/bsm_mid.sv =====
// ----------------------------------------------------------------------------
// bsm_mid
// Merged radius, step products and growth (three stages).
// ----------------------------------------------------------------------------
module bsm_mid import bsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  ctx_t                ctx_i,
  input  logic [RootW-1:0]    dist_i,
  output logic                vld_o,
  output ctx_t                ctx_o,
  output logic [2:0][NumW-1:0] num_o
);

  logic [33:0] sum;
  logic [32:0] r, step_d;
  ctx_t        ca_d, cc_d;

  logic [2:0]          v_q;
  ctx_t                ca_q, cb_q, cc_q;
  logic [32:0]         step_q, x_q;
  logic [2:0][65:0]    num_q, numc_q;
  logic [65:0]         xx_q, g;
  logic [61:0]         aa_q;

  always_comb begin
    sum    = 34'(dist_i) + 34'(ctx_i.ra) + 34'(ctx_i.rb);
    r      = sum[33:1];
    step_d = r - {2'b00, ctx_i.ra};
    g      = xx_q - {4'b0, aa_q};
    ca_d      = ctx_i;
    ca_d.span = dist_i;
    ca_d.r    = r;
    cc_d      = cb_q;
    if (cb_q.contained && (cb_q.ra > cb_q.rb)) begin
      cc_d.growth = '0;
    end else if (g[65:63] != 3'b000) begin
      cc_d.growth = GrowthMax;
    end else begin
      cc_d.growth = g[62:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q      <= ca_d;
    step_q    <= step_d;
    x_q       <= ctx_i.contained ? {2'b00, ctx_i.rb} : r;

    cb_q <= ca_q;
    for (int i = 0; i < 3; i++) begin
      num_q[i] <= 66'(ca_q.ad[i]) * 66'(step_q);
    end
    xx_q <= 66'(x_q) * 66'(x_q);
    aa_q <= 62'(ca_q.ra) * 62'(ca_q.ra);

    cc_q   <= cc_d;
    numc_q <= num_q;
  end

  assign vld_o = v_q[2];
  assign ctx_o = cc_q;
  assign num_o = numc_q;

endmodule

// ===== rtl/bsm_div_cell.sv =====
// ----------------------------------------------------------------------------
// bsm_div_cell
// One quotient bit of the three centre step divisions.
// ----------------------------------------------------------------------------
module bsm_div_cell import bsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  ctx_t                  ctx_i,
  input  logic [2:0][QuoW-1:0]  rem_i,
  input  logic [2:0][QuoW-1:0]  num_i,
  input  logic [2:0][QuoW-1:0]  quo_i,
  output logic                  vld_o,
  output ctx_t                  ctx_o,
  output logic [2:0][QuoW-1:0]  rem_o,
  output logic [2:0][QuoW-1:0]  num_o,
  output logic [2:0][QuoW-1:0]  quo_o
);

  logic [2:0][QuoW-1:0] rem_d, quo_d;
  logic                 vld_q;
  ctx_t                 ctx_q;
  logic [2:0][QuoW-1:0] rem_q, num_q, quo_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QuoW:0] t;
      t = {rem_i[i], num_i[i][QuoW-1]};
      if (t >= {1'b0, ctx_i.span}) begin
        rem_d[i] = QuoW'(t - {1'b0, ctx_i.span});
        quo_d[i] = {quo_i[i][QuoW-2:0], 1'b1};
      end else begin
        rem_d[i] = t[QuoW-1:0];
        quo_d[i] = {quo_i[i][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_i;
    rem_q <= rem_d;
    quo_q <= quo_d;
    for (int i = 0; i < 3; i++) begin
      num_q[i] <= {num_i[i][QuoW-2:0], 1'b0};
    end
  end

  assign vld_o = vld_q;
  assign ctx_o = ctx_q;
  assign rem_o = rem_q;
  assign num_o = num_q;
  assign quo_o = quo_q;

endmodule

// ===== tb/tb_bounding_sphere_merge_top.sv =====
// ----------------------------------------------------------------------------
// tb_bounding_sphere_merge_top
// Self-checking bench for the bounding sphere merge pipeline: sphere pairs are
// sent with random gaps, every result is predicted and compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounding_sphere_merge_top;
  import bsm_pkg::*;

  typedef struct {
    in_t pair;
    int  gap;
    bit  drain;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  req_i = '0;
  out_t res_o;
  logic res_vld_o;

  pend_t pair_q[$];
  out_t  merged_q[$];
  int    gap_cnt = 0;
  int    errors = 0;
  int    cycles = 0;

  bounding_sphere_merge_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .res_o(res_o), .res_vld_o(res_vld_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_t enclosing_sphere(in_t p);
    longint      ac[3], bc[3], d[3], c;
    logic [127:0] ad[3], d2, rd, rd2, root, t, r, step, g, q;
    logic [127:0] ra, rb;
    out_t o;
    ac[0] = p.a_centre_x; ac[1] = p.a_centre_y; ac[2] = p.a_centre_z;
    bc[0] = p.b_centre_x; bc[1] = p.b_centre_y; bc[2] = p.b_centre_z;
    ra = p.a_radius;
    rb = p.b_radius;
    d2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = bc[i] - ac[i];
      ad[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
      d2 += ad[i] * ad[i];
    end
    rd = (rb >= ra) ? rb - ra : ra - rb;
    rd2 = rd * rd;
    o = '0;
    if (d2 <= rd2) begin
      if (ra > rb) begin
        o.merged_centre_x = p.a_centre_x;
        o.merged_centre_y = p.a_centre_y;
        o.merged_centre_z = p.a_centre_z;
        o.merged_radius = p.a_radius;
        o.growth = '0;
      end else begin
        o.merged_centre_x = p.b_centre_x;
        o.merged_centre_y = p.b_centre_y;
        o.merged_centre_z = p.b_centre_z;
        o.merged_radius = p.b_radius;
        g = rb * rb - ra * ra;
        o.growth = g[62:0];
      end
      o.contained = 1'b1;
      return o;
    end
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      t = root | (128'd1 << b);
      if (t * t <= d2) root = t;
    end
    r = (root + ra + rb) >> 1;
    step = r - ra;
    g = r * r - ra * ra;
    for (int i = 0; i < 3; i++) begin
      c = ac[i];
      if (root != 0) begin
        q = (ad[i] * step) / root;
        c = (d[i] < 0) ? c - longint'(q[63:0]) : c + longint'(q[63:0]);
      end
      case (i)
        0: o.merged_centre_x = c[31:0];
        1: o.merged_centre_y = c[31:0];
        default: o.merged_centre_z = c[31:0];
      endcase
    end
    o.merged_radius = (r > 128'(RadiusMax)) ? RadiusMax : r[30:0];
    o.growth = (g > 128'(GrowthMax)) ? GrowthMax : g[62:0];
    o.contained = 1'b0;
    return o;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    logic  accepted;
    pend_t nx;
    accepted = start && !busy;
    if (accepted) merged_q.push_back(enclosing_sphere(req_i));
    if (rst_ni && (!start || accepted)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start <= 1'b0;
      end else if (pair_q.size() != 0 && !(pair_q[0].drain && merged_q.size() != 0)) begin
        nx = pair_q.pop_front();
        req_i <= nx.pair;
        start <= 1'b1;
        gap_cnt <= nx.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_vld_o) begin
      if (merged_q.size() == 0) begin
        report("unexpected result", 64'(res_o.merged_radius), 64'd0);
      end else begin
        want = merged_q.pop_front();
        if (res_o.merged_centre_x !== want.merged_centre_x)
          report("centre_x", 64'(res_o.merged_centre_x), 64'(want.merged_centre_x));
        if (res_o.merged_centre_y !== want.merged_centre_y)
          report("centre_y", 64'(res_o.merged_centre_y), 64'(want.merged_centre_y));
        if (res_o.merged_centre_z !== want.merged_centre_z)
          report("centre_z", 64'(res_o.merged_centre_z), 64'(want.merged_centre_z));
        if (res_o.merged_radius !== want.merged_radius)
          report("radius", 64'(res_o.merged_radius), 64'(want.merged_radius));
        if (res_o.growth !== want.growth)
          report("growth", 64'(res_o.growth), 64'(want.growth));
        if (res_o.contained !== want.contained)
          report("contained", 64'(res_o.contained), 64'(want.contained));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 4))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 32'h4000_0000));
      2: return 31'($urandom_range(0, 32'h0008_0000));
      3: return $urandom_range(0, 1) ? 31'h4000_0000 : 31'h7FFF_FFFF;
      default: return '0;
    endcase
  endfunction

  function automatic in_t rand_pair();
    in_t p;
    logic [31:0] off;
    p.a_centre_x = rand_coord();
    p.a_centre_y = rand_coord();
    p.a_centre_z = rand_coord();
    p.a_radius = rand_radius();
    p.b_radius = rand_radius();
    case ($urandom_range(0, 3))
      0: begin
        p.b_centre_x = rand_coord();
        p.b_centre_y = rand_coord();
        p.b_centre_z = rand_coord();
      end
      default: begin
        // nearby centres, often one sphere inside the other
        off = $urandom_range(0, 32'h0004_0000);
        p.b_centre_x = p.a_centre_x + off - 32'h0002_0000;
        off = $urandom_range(0, 32'h0004_0000);
        p.b_centre_y = p.a_centre_y + off - 32'h0002_0000;
        off = $urandom_range(0, 32'h0004_0000);
        p.b_centre_z = p.a_centre_z + off - 32'h0002_0000;
      end
    endcase
    return p;
  endfunction

  task automatic add_pair(in_t p, int gap, bit drain);
    pend_t e;
    e.pair = p;
    e.gap = gap;
    e.drain = drain;
    pair_q.push_back(e);
  endtask

  initial begin
    bit quiet;
    add_pair('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'd0}, 0, 1'b0);
    add_pair('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF}, 2, 1'b0);
    add_pair('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h4000_0000,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h4000_0000}, 0, 1'b0);
    // identical spheres: tie goes to the second
    add_pair('{32'sd1000, -32'sd5, 32'sd0, 31'd65536,
               32'sd1000, -32'sd5, 32'sd0, 31'd65536}, 1, 1'b0);
    add_pair('{32'sd0, 32'sd0, 32'sd0, 31'd0, 32'sd0, 32'sd0, 32'sd0, 31'd0}, 0, 1'b0);
    // first encloses second
    add_pair('{32'sd0, 32'sd0, 32'sd0, 31'h0010_0000,
               32'sd65536, 32'sd0, 32'sd0, 31'h0001_0000}, 0, 1'b0);
    // second encloses first, boundary touching
    add_pair('{32'sd0, 32'sd0, 32'sd0, 31'h0001_0000,
               32'sh0003_0000, 32'sd0, 32'sd0, 31'h0004_0000}, 3, 1'b0);
    // disjoint spheres along each axis, negative offsets too
    add_pair('{32'sd0, 32'sd0, 32'sd0, 31'h0001_0000,
               -32'sh0005_0000, 32'sd0, 32'sd0, 31'h0001_0000}, 0, 1'b0);
    add_pair('{32'sd0, 32'sd0, 32'sd0, 31'h0001_0000,
               32'sd0, 32'sh0005_0000, 32'sd0, 31'h0002_0000}, 0, 1'b0);
    add_pair('{32'sd0, 32'sd0, 32'sd0, 31'h0002_0000,
               32'sd0, 32'sd0, -32'sh0005_0000, 31'h0001_0000}, 0, 1'b0);
    add_pair('{32'sd3, -32'sd7, 32'sd11, 31'd0, -32'sd2, 32'sd9, 32'sd4, 31'd1}, 0, 1'b0);
    add_pair('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 31'h7FFF_FFFF,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 31'd0}, 0, 1'b0);
    for (int n = 0; n < 600; n++) begin
      if (n % 40 == 0) quiet = $urandom_range(0, 1);
      add_pair(rand_pair(), quiet ? 0 : $urandom_range(0, 12), n == 0 || n == 300);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pair_q.size() != 0 || start) @(posedge clk_i);
    while (merged_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
